### rtl/sixteen_bit_instruction_decoder_core_defines.svh
// Assertion macros shared by the decoder RTL.
`ifndef SIXTEEN_BIT_INSTRUCTION_DECODER_CORE_DEFINES_SVH
`define SIXTEEN_BIT_INSTRUCTION_DECODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// check an implication on every rising clock edge outside reset
`define SBID_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sbid assertion failed");
// check that a condition never holds outside reset
`define SBID_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sbid forbidden condition seen");
`else
`define SBID_ASSERT(lbl, clk, rst_n, prop)
`define SBID_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### rtl/sbid_pkg.sv
// Types and constants of the sixteen-bit instruction decoder.
package sbid_pkg;

  localparam int unsigned InstrWidth = 16;

  typedef enum logic [4:0] {
    OP_AND     = 5'd0,
    OP_OR      = 5'd1,
    OP_ADD     = 5'd2,
    OP_SUB     = 5'd3,
    OP_MULT    = 5'd4,
    OP_XOR     = 5'd5,
    OP_LSL     = 5'd6,
    OP_LSR     = 5'd7,
    OP_LSL8    = 5'd8,
    OP_LSR8    = 5'd9,
    OP_ASL     = 5'd10,
    OP_ASR     = 5'd11,
    OP_SETF    = 5'd12,
    OP_CLRF    = 5'd13,
    OP_SAVEF   = 5'd14,
    OP_RSTRF   = 5'd15,
    OP_INC     = 5'd16,
    OP_DEC     = 5'd17,
    OP_LOAD    = 5'd18,
    OP_STORE   = 5'd19,
    OP_SETLO   = 5'd20,
    OP_SETHI   = 5'd21,
    OP_SWI     = 5'd22,
    OP_RTI     = 5'd23,
    OP_RETURN  = 5'd24,
    OP_BRANCHR = 5'd25,
    OP_BRANCH  = 5'd26,
    OP_CALL    = 5'd27
  } op_t;

  localparam logic [3:0] GRP_CALL  = 4'h2;
  localparam logic [3:0] GRP_MISC  = 4'h3;
  localparam logic [3:0] SUB_SETF  = 4'h6;
  localparam logic [3:0] SUB_SAVEF = 4'h7;

  localparam logic [15:0] SWI_MASK    = 16'hfff0;
  localparam logic [15:0] SWI_BASE    = 16'h1100;
  localparam logic [15:0] RTI_WORD    = 16'h1110;
  localparam logic [15:0] RETURN_WORD = 16'h1111;

  typedef struct packed {
    op_t        operation;
    logic [3:0] dest_reg;
    logic [3:0] src_a_reg;
    logic [3:0] src_b_reg;
    logic [7:0] imm_byte;
    logic [5:0] imm_amount;
    logic [4:0] five_bit_field;
    logic [3:0] branch_cond;
    logic [3:0] interrupt_number;
  } sbid_result_t;

  localparam int unsigned ResultWidth = $bits(sbid_result_t);

endpackage

### rtl/sbid_in_if.sv
// Instruction channel interface.
interface sbid_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink (input valid, input instruction, output ready);
endinterface

### rtl/sbid_out_if.sv
// Decoded result channel interface.
interface sbid_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] operation;
  logic [3:0] dest_reg;
  logic [3:0] src_a_reg;
  logic [3:0] src_b_reg;
  logic [7:0] imm_byte;
  logic [5:0] imm_amount;
  logic [4:0] five_bit_field;
  logic [3:0] branch_cond;
  logic [3:0] interrupt_number;

  modport source (
    output valid, output operation, output dest_reg, output src_a_reg,
    output src_b_reg, output imm_byte, output imm_amount,
    output five_bit_field, output branch_cond, output interrupt_number,
    input ready
  );
  modport sink (
    input valid, input operation, input dest_reg, input src_a_reg,
    input src_b_reg, input imm_byte, input imm_amount,
    input five_bit_field, input branch_cond, input interrupt_number,
    output ready
  );
endinterface

### rtl/sbid_stage.sv
// Pipeline register stage with valid/ready handshake.
module sbid_stage #(
  parameter int unsigned W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  logic [W-1:0] up_data,
  output logic         dn_valid,
  input  logic         dn_ready,
  output logic [W-1:0] dn_data
);

  logic         valid_r;
  logic         valid_nxt;
  logic [W-1:0] data_r;

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_valid || (valid_r && !dn_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= up_data;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

### rtl/sbid_decode.sv
// Combinational decode of one instruction word into operation and fields.
module sbid_decode
  import sbid_pkg::*;
(
  input  logic [15:0]  instr,
  output sbid_result_t res
);

  logic [3:0] top;
  logic [3:0] n2;
  logic [3:0] n1;
  logic [3:0] n0;

  assign top = instr[15:12];
  assign n2  = instr[11:8];
  assign n1  = instr[7:4];
  assign n0  = instr[3:0];

  always_comb begin
    res = '0;
    res.operation = OP_AND;
    case (top) inside
      [4'h8:4'hd]: begin
        res.operation = op_t'({1'b0, 4'(top - 4'h8)});
        res.dest_reg  = n2;
        res.src_a_reg = n1;
        res.src_b_reg = n0;
      end
      GRP_MISC: begin
        case (n1) inside
          [4'h0:4'h5]: begin
            res.operation = op_t'(5'(OP_LSL) + {1'b0, n1});
            res.dest_reg  = n2;
            res.src_b_reg = n0;
          end
          SUB_SETF: begin
            res.operation      = instr[11] ? OP_CLRF : OP_SETF;
            res.five_bit_field = {instr[8], n0};
          end
          SUB_SAVEF: begin
            res.operation = instr[3] ? OP_RSTRF : OP_SAVEF;
            res.dest_reg  = n2;
          end
          default: begin
            res.operation  = instr[6] ? OP_DEC : OP_INC;
            res.dest_reg   = n2;
            res.imm_amount = instr[5:0];
          end
        endcase
      end
      [4'h4:4'h7]: begin
        res.operation      = instr[13] ? OP_STORE : OP_LOAD;
        res.dest_reg       = n2;
        res.src_b_reg      = n0;
        res.five_bit_field = {instr[12], n1};
      end
      [4'he:4'hf]: begin
        res.operation = instr[12] ? OP_SETHI : OP_SETLO;
        res.dest_reg  = n2;
        res.imm_byte  = instr[7:0];
      end
      GRP_CALL: begin
        res.operation = OP_CALL;
        res.imm_byte  = instr[11:4];
        res.src_b_reg = n0;
      end
      default: begin
        if ((instr & SWI_MASK) == SWI_BASE) begin
          res.operation        = OP_SWI;
          res.interrupt_number = n0;
        end else if (instr == RTI_WORD) begin
          res.operation = OP_RTI;
        end else if (instr == RETURN_WORD) begin
          res.operation = OP_RETURN;
        end else if (!instr[12]) begin
          res.operation   = OP_BRANCHR;
          res.branch_cond = n2;
          res.imm_byte    = instr[7:0];
        end else begin
          res.operation   = OP_BRANCH;
          res.branch_cond = n2;
          res.src_b_reg   = n0;
        end
      end
    endcase
  end

endmodule

### rtl/sixteen_bit_instruction_decoder_core.sv
// Top level of the sixteen-bit instruction decoder.
//
//   channel  | modport           | payload
//   in_bus   | sbid_in_if.sink   | instruction[15:0]
//   out_bus  | sbid_out_if.source| operation and eight operand fields
//
// One instruction word enters per cycle unless a stall fills both registers;
// its result passes the input register, decode and result register.
// Synchronous active-low reset empties both registers; no clearing pass.
// A stalled result holds in the result register while the input register
// still takes one more beat; ready falls only when both are full.
`include "sixteen_bit_instruction_decoder_core_defines.svh"
module sixteen_bit_instruction_decoder_core
  import sbid_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  sbid_in_if.sink           in_bus,
  sbid_out_if.source        out_bus
);

  logic                   s1_valid;
  logic                   s1_ready;
  logic [InstrWidth-1:0]  s1_instr;
  sbid_result_t           dec_res;
  sbid_result_t           out_res;
  logic [ResultWidth-1:0] out_bits;

  sbid_stage #(.W(InstrWidth)) u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_bus.valid),
    .up_ready (in_bus.ready),
    .up_data  (in_bus.instruction),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_instr)
  );

  sbid_decode u_decode (
    .instr (s1_instr),
    .res   (dec_res)
  );

  sbid_stage #(.W(ResultWidth)) u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (dec_res),
    .dn_valid (out_bus.valid),
    .dn_ready (out_bus.ready),
    .dn_data  (out_bits)
  );

  assign out_res                  = sbid_result_t'(out_bits);
  assign out_bus.operation        = out_res.operation;
  assign out_bus.dest_reg         = out_res.dest_reg;
  assign out_bus.src_a_reg        = out_res.src_a_reg;
  assign out_bus.src_b_reg        = out_res.src_b_reg;
  assign out_bus.imm_byte         = out_res.imm_byte;
  assign out_bus.imm_amount       = out_res.imm_amount;
  assign out_bus.five_bit_field   = out_res.five_bit_field;
  assign out_bus.branch_cond      = out_res.branch_cond;
  assign out_bus.interrupt_number = out_res.interrupt_number;

  `SBID_ASSERT(a_in_to_s1, clk, rst_n, (in_bus.valid && in_bus.ready) |=> s1_valid)
  `SBID_ASSERT(a_s1_to_out, clk, rst_n, (s1_valid && s1_ready) |=> out_bus.valid)
  `SBID_ASSERT_NEVER(a_op_range, clk, rst_n, out_bus.valid && (out_bus.operation > 5'(OP_CALL)))
  `SBID_ASSERT(a_rti_clean, clk, rst_n, (out_bus.valid && out_bus.operation == 5'(OP_RTI)) |-> (out_bits[ResultWidth-6:0] == '0))

endmodule

### tb/tb.sv
// Testbench for the sixteen-bit instruction decoder: random and directed words.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbid_pkg::*;

  localparam logic [3:0] GRP_ALU_FIRST = 4'h8;
  localparam logic [3:0] GRP_ALU_LAST  = 4'hD;
  localparam logic [3:0] GRP_SET       = 4'hE;
  localparam logic [3:0] SUB_LAST_SHIFT = 4'h5;
  localparam int unsigned RANDOM_WORDS = 1620;
  localparam int unsigned LONG_HOLD    = 60;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;

  class decode_scoreboard;
    sbid_result_t pending[$];
    int unsigned  mismatches;
    int unsigned  results_checked;
    logic [31:0]  ops_seen;

    function new();
      mismatches = 0;
      results_checked = 0;
      ops_seen = '0;
    endfunction

    function sbid_result_t decode_word(logic [15:0] w);
      sbid_result_t r;
      logic [3:0] grp, hi, mid, lo;
      r   = '0;
      grp = w[15:12];
      hi  = w[11:8];
      mid = w[7:4];
      lo  = w[3:0];
      if (grp >= GRP_ALU_FIRST && grp <= GRP_ALU_LAST) begin
        r.operation = op_t'(OP_AND + (grp - GRP_ALU_FIRST));
        r.dest_reg  = hi;
        r.src_a_reg = mid;
        r.src_b_reg = lo;
      end else if (grp == GRP_MISC) begin
        if (mid <= SUB_LAST_SHIFT) begin
          r.operation = op_t'(OP_LSL + mid);
          r.dest_reg  = hi;
          r.src_b_reg = lo;
        end else if (mid == SUB_SETF) begin
          r.operation      = w[11] ? OP_CLRF : OP_SETF;
          r.five_bit_field = {w[8], lo};
        end else if (mid == SUB_SAVEF) begin
          r.operation = w[3] ? OP_RSTRF : OP_SAVEF;
          r.dest_reg  = hi;
        end else begin
          r.operation  = w[6] ? OP_DEC : OP_INC;
          r.dest_reg   = hi;
          r.imm_amount = w[5:0];
        end
      end else if (grp[3:2] == 2'b01) begin
        r.operation      = w[13] ? OP_STORE : OP_LOAD;
        r.dest_reg       = hi;
        r.src_b_reg      = lo;
        r.five_bit_field = {w[12], mid};
      end else if (grp >= GRP_SET) begin
        r.operation = w[12] ? OP_SETHI : OP_SETLO;
        r.dest_reg  = hi;
        r.imm_byte  = w[7:0];
      end else if (grp == GRP_CALL) begin
        r.operation = OP_CALL;
        r.imm_byte  = w[11:4];
        r.src_b_reg = lo;
      end else if ((w & SWI_MASK) == SWI_BASE) begin
        r.operation        = OP_SWI;
        r.interrupt_number = lo;
      end else if (w == RTI_WORD) begin
        r.operation = OP_RTI;
      end else if (w == RETURN_WORD) begin
        r.operation = OP_RETURN;
      end else if (!w[12]) begin
        r.operation   = OP_BRANCHR;
        r.branch_cond = hi;
        r.imm_byte    = w[7:0];
      end else begin
        r.operation   = OP_BRANCH;
        r.branch_cond = hi;
        r.src_b_reg   = lo;
      end
      return r;
    endfunction

    function void note_word(logic [15:0] w);
      pending.push_back(decode_word(w));
    endfunction

    function void check_field(string fname, logic [7:0] want_v, logic [7:0] got_v);
      if (got_v !== want_v) begin
        mismatches++;
        if (mismatches <= 50)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want_v, got_v);
      end
    endfunction

    function void check_result(sbid_result_t got);
      sbid_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 50)
          $display("%0t: result with none expected, expected none, actual operation %0d",
                   $time, got.operation);
        return;
      end
      want = pending.pop_front();
      results_checked++;
      ops_seen[want.operation] = 1'b1;
      check_field("operation", 8'(want.operation), 8'(got.operation));
      check_field("dest_reg", 8'(want.dest_reg), 8'(got.dest_reg));
      check_field("src_a_reg", 8'(want.src_a_reg), 8'(got.src_a_reg));
      check_field("src_b_reg", 8'(want.src_b_reg), 8'(got.src_b_reg));
      check_field("imm_byte", want.imm_byte, got.imm_byte);
      check_field("imm_amount", 8'(want.imm_amount), 8'(got.imm_amount));
      check_field("five_bit_field", 8'(want.five_bit_field), 8'(got.five_bit_field));
      check_field("branch_cond", 8'(want.branch_cond), 8'(got.branch_cond));
      check_field("interrupt_number", 8'(want.interrupt_number), 8'(got.interrupt_number));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  sbid_in_if  in_ch ();
  sbid_out_if out_ch ();

  sixteen_bit_instruction_decoder_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch)
  );

  decode_scoreboard sb = new();

  bit          send_gaps_on;
  bit          recv_stalls_on;
  bit          long_hold_req;
  int unsigned hold_left;
  int unsigned idle_cycles;
  int unsigned words_sent;
  logic [15:0] directed_words [30];

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.instruction = '0;
    out_ch.ready = 1'b0;
  end

  function automatic logic [15:0] random_word();
    case ($urandom_range(0, 9))
      0: return SWI_BASE | 16'($urandom_range(0, 31));
      1, 2: return {GRP_MISC, 12'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(logic [15:0] w);
    if (send_gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.instruction <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (recv_stalls_on && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 4) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    sbid_result_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_word(in_ch.instruction);
      if (out_ch.valid && out_ch.ready) begin
        got.operation        = op_t'(out_ch.operation);
        got.dest_reg         = out_ch.dest_reg;
        got.src_a_reg        = out_ch.src_a_reg;
        got.src_b_reg        = out_ch.src_b_reg;
        got.imm_byte         = out_ch.imm_byte;
        got.imm_amount       = out_ch.imm_amount;
        got.five_bit_field   = out_ch.five_bit_field;
        got.branch_cond      = out_ch.branch_cond;
        got.interrupt_number = out_ch.interrupt_number;
        sb.check_result(got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    words_sent = 0;
    long_hold_req = 1'b0;
    send_gaps_on = 1'b1;
    recv_stalls_on = 1'b1;
    directed_words = '{
      16'h0000, 16'h0FFF, 16'h1100, 16'h110F, 16'h1110, 16'h1111, 16'h1112, 16'h2FFF,
      16'h3A0F, 16'h3F1F, 16'h3020, 16'h3531, 16'h3C4A, 16'h3F5F, 16'h316F, 16'h3E6F,
      16'h3F77, 16'h3078, 16'h3FBF, 16'h30C0, 16'h5FFF, 16'h6000, 16'hE0FF, 16'hFFFF,
      16'h8000, 16'h9FFF, 16'hA5A5, 16'hB3C1, 16'hC7E2, 16'hDFFF
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_words[i]) send_word(directed_words[i]);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 400)
        long_hold_req = 1'b1;
      if (i == 800) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait_drained();
      end
      if (i == RANDOM_WORDS - 200) begin
        send_gaps_on = 1'b0;
        recv_stalls_on = 1'b0;
      end
      send_word(random_word());
    end
    in_ch.valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d words sent, %0d results checked, %0d of 28 operations decoded",
             words_sent, sb.results_checked, $countones(sb.ops_seen));
    $display("covered random stalls on both sides, a long receiver hold and a full drain");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
